// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/core/esd_pkg.sv
// Shared types, character codes and helpers of the escape sequence decoder.
package esd_pkg;

  // Character codes
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChBel       = 8'h07;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChPeriod    = 8'h2E;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChDigit0    = 8'h30;
  localparam logic [7:0] ChDigit9    = 8'h39;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperF    = 8'h46;
  localparam logic [7:0] ChUpperH    = 8'h48;
  localparam logic [7:0] ChUpperN    = 8'h4E;
  localparam logic [7:0] ChUpperR    = 8'h52;
  localparam logic [7:0] ChUpperX    = 8'h58;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerH    = 8'h68;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerX    = 8'h78;

  // Output queue geometry
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_ESC   = 3'd1,
    PH_X_HI  = 3'd2,
    PH_X_LO  = 3'd3,
    PH_H_HI  = 3'd4,
    PH_H_LO  = 3'd5
  } esd_phase_e;

  // Up to two decoded bytes produced by one input word
  typedef struct packed {
    logic [1:0] num;
    logic [7:0] b0;
    logic [7:0] b1;
  } esd_res_t;

  // One queued output word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esd_word_t;

  // Hex digit value; anything that is not a hex digit counts as zero.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= ChDigit0 && c <= ChDigit9) begin
      d = c - ChDigit0;
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      d = c - ChUpperA + 8'd10;
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      d = c - ChLowerA + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

// File: rtl/core/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: input register, decoder, output queue.
//
//   channel | direction | payload                     | handshake
//   --------+-----------+-----------------------------+--------------------
//   in      | to block  | in_byte_i                   | in_valid_i/in_stall_o
//   out     | from block| out_byte_o, last_of_run_o   | out_valid_o/out_stall_i
//
// One word in per cycle while in_stall_o is low; a word's first byte is offered on
// the output once it has passed the input register and then the four-entry output
// queue, and a second byte follows it.
// The input register decodes and pushes only while the queue has room for two
// bytes, so the queue depth sets how much output back-pressure is absorbed.
// Reset (rst_ni low, asynchronous) empties the queue and returns to plain text.
// A stall on either side holds the waiting word; nothing is dropped.
`include "assert_macros.svh"

module escape_sequence_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic                          in_valid_q;
  logic [7:0]                    in_byte_q;
  logic                          fire;
  logic                          room;
  esd_pkg::esd_res_t             res;
  logic [esd_pkg::CntW-1:0]      count;

  // Room for the worst case of two bytes; count is registered, so the stall
  // never depends combinationally on the downstream stall.
  assign room       = ({1'b0, count} + (esd_pkg::CntW+1)'(2))
                      <= (esd_pkg::CntW+1)'(esd_pkg::QueueDepth);
  assign in_stall_o = in_valid_q && !room;
  assign fire       = in_valid_q && room;

  // Hold the input word while stalled, otherwise advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  esd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  esd_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (fire),
    .res_i         (res),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .count_o       (count)
  );

  // Queue never holds more words than it has entries.
  `ASSERT_CLK(a_queue_bound, count <= esd_pkg::CntW'(esd_pkg::QueueDepth), "output queue overflow")
  // Stall only while a word sits in the input register.
  `ASSERT_CLK(a_stall_held, in_stall_o |-> in_valid_q, "stall without a held word")
  // End of string yields no output byte.
  `ASSERT_CLK(a_nul_silent, (fire && in_byte_q == esd_pkg::ChNul) |-> (res.num == 2'd0), "NUL produced output")
  // Output side is only valid when the queue holds a word.
  `ASSERT_CLK(a_valid_count, out_valid_o == (count != '0), "output valid disagrees with queue")

endmodule

// File: rtl/core/esd_decode.sv
// Escape decoder: phase state and per-word decode into up to two bytes.
module esd_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output esd_pkg::esd_res_t res_o
);

  esd_pkg::esd_phase_e phase_q, phase_d;
  logic [7:0]          hi_q, hi_d;
  logic [7:0]          esc_q, esc_d;

  always_comb begin
    phase_d = phase_q;
    hi_d    = hi_q;
    esc_d   = esc_q;
    res_o   = '0;
    if (byte_i == esd_pkg::ChNul) begin
      // end of string: drop anything pending
      phase_d = esd_pkg::PH_PLAIN;
      hi_d    = '0;
      esc_d   = '0;
    end else begin
      case (phase_q)
        esd_pkg::PH_ESC: begin
          phase_d = esd_pkg::PH_PLAIN;
          if (byte_i inside {esd_pkg::ChSlash, esd_pkg::ChBackslash}) begin
            res_o.num = 2'd1;
            res_o.b0  = byte_i;
          end else if (byte_i inside {esd_pkg::ChLowerR, esd_pkg::ChUpperR}) begin
            res_o.num = 2'd1;
            res_o.b0  = esd_pkg::ChCr;
          end else if (byte_i inside {esd_pkg::ChLowerN, esd_pkg::ChUpperN}) begin
            res_o.num = 2'd1;
            res_o.b0  = esd_pkg::ChLf;
          end else if (byte_i inside {esd_pkg::ChLowerA, esd_pkg::ChUpperA}) begin
            res_o.num = 2'd1;
            res_o.b0  = esd_pkg::ChBel;
          end else if (byte_i inside {esd_pkg::ChLowerX, esd_pkg::ChUpperX}) begin
            phase_d = esd_pkg::PH_X_HI;
          end else if (byte_i inside {esd_pkg::ChLowerH, esd_pkg::ChUpperH}) begin
            phase_d = esd_pkg::PH_H_HI;
          end else if (byte_i == esd_pkg::ChDigit0) begin
            res_o.num = 2'd1;
            res_o.b0  = esd_pkg::ChNul;
          end else begin
            // unknown escape: replay the escape character, then the byte
            res_o.num = 2'd2;
            res_o.b0  = esc_q;
            res_o.b1  = byte_i;
          end
        end
        esd_pkg::PH_X_HI: begin
          hi_d    = byte_i;
          phase_d = esd_pkg::PH_X_LO;
        end
        esd_pkg::PH_X_LO: begin
          res_o.num = 2'd1;
          res_o.b0  = {esd_pkg::hex_val(hi_q), esd_pkg::hex_val(byte_i)};
          phase_d   = esd_pkg::PH_PLAIN;
        end
        esd_pkg::PH_H_HI: begin
          if (byte_i == esd_pkg::ChPeriod) begin
            phase_d = esd_pkg::PH_PLAIN;
          end else begin
            hi_d    = byte_i;
            phase_d = esd_pkg::PH_H_LO;
          end
        end
        esd_pkg::PH_H_LO: begin
          res_o.num = 2'd1;
          res_o.b0  = {esd_pkg::hex_val(hi_q), esd_pkg::hex_val(byte_i)};
          phase_d   = esd_pkg::PH_H_HI;
        end
        default: begin
          phase_d = esd_pkg::PH_PLAIN;
          if (byte_i inside {esd_pkg::ChSlash, esd_pkg::ChBackslash}) begin
            esc_d   = byte_i;
            phase_d = esd_pkg::PH_ESC;
          end else begin
            res_o.num = 2'd1;
            res_o.b0  = byte_i;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= esd_pkg::PH_PLAIN;
      hi_q    <= '0;
      esc_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
      esc_q   <= esc_d;
    end
  end

endmodule

// File: rtl/core/esd_out_fifo.sv
// Output queue: takes up to two bytes per cycle, hands out one per cycle while out_stall_i is low.
module esd_out_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  esd_pkg::esd_res_t         res_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [7:0]                out_byte_o,
  output logic                      last_of_run_o,
  output logic [esd_pkg::CntW-1:0]  count_o
);

  esd_pkg::esd_word_t            mem_q [esd_pkg::QueueDepth];
  logic [esd_pkg::PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [esd_pkg::CntW-1:0]      count_q, count_d;
  logic [esd_pkg::PtrW-1:0]      wr_ptr_nx;
  logic [1:0]                    num;
  logic                          pop;

  assign num       = push_i ? res_i.num : 2'd0;
  assign pop       = (count_q != '0) && !out_stall_i;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + num[esd_pkg::PtrW-1:0];
    rd_ptr_d = rd_ptr_q + {{(esd_pkg::PtrW-1){1'b0}}, pop};
    count_d  = count_q + {{(esd_pkg::CntW-2){1'b0}}, num}
             - {{(esd_pkg::CntW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      mem_q[wr_ptr_q] <= '{data: res_i.b0, last: (num == 2'd1)};
    end
    if (num == 2'd2) begin
      mem_q[wr_ptr_nx] <= '{data: res_i.b1, last: 1'b1};
    end
  end

  assign out_valid_o   = (count_q != '0);
  assign out_byte_o    = mem_q[rd_ptr_q].data;
  assign last_of_run_o = mem_q[rd_ptr_q].last;
  assign count_o       = count_q;

endmodule
